### hdl/int8_dot_dequantize_assert.svh
// Assertion macros for the int8 dot product and dequantize block.
// Included by the top level; depends on nothing else.
`ifndef INT8_DOT_DEQUANTIZE_ASSERT_SVH
`define INT8_DOT_DEQUANTIZE_ASSERT_SVH

// same-cycle implication
`define I8DD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I8DD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/i8dd_pkg.sv
// Shared widths, step codes and controller/datapath command types
// for the int8 dot product and dequantize block. No dependencies.
`default_nettype none

package i8dd_pkg;

   localparam int BYTE_W   = 8;
   localparam int ROWSUM_W = 21;
   localparam int SCALE_W  = 32;
   localparam int OUT_W    = 64;
   localparam int ACC_W    = 40;
   localparam int ZR_W     = BYTE_W + ROWSUM_W;
   localparam int DIFF_W   = ACC_W + 1;
   localparam int MUL_W    = 32;
   localparam int SPROD_W  = 2 * SCALE_W;
   localparam int PROD_W   = DIFF_W + SPROD_W;

   // partial product order over the shared multiplier
   localparam logic [1:0] MUL_LL = 2'd0;
   localparam logic [1:0] MUL_LH = 2'd1;
   localparam logic [1:0] MUL_HL = 2'd2;
   localparam logic [1:0] MUL_HH = 2'd3;

   localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic       accept;
      logic       diff_en;
      logic       mag_en;
      logic       mul_en;
      logic [1:0] mul_step;
      logic       round_en;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### hdl/i8dd_req_if.sv
// Request channel: one weight/activation pair plus end-of-run fields.
// Depends on i8dd_pkg.
`default_nettype none

interface i8dd_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [i8dd_pkg::BYTE_W-1:0]     weight_byte;
   logic signed [i8dd_pkg::BYTE_W-1:0]     activation_byte;
   logic                                   last;
   logic signed [i8dd_pkg::BYTE_W-1:0]     zero_point;
   logic signed [i8dd_pkg::ROWSUM_W-1:0]   row_sum;
   logic        [i8dd_pkg::SCALE_W-1:0]    wgt_scale;
   logic        [i8dd_pkg::SCALE_W-1:0]    act_scale;

   modport source (
      output valid, weight_byte, activation_byte, last, zero_point, row_sum,
             wgt_scale, act_scale,
      input  ready
   );
   modport sink (
      input  valid, weight_byte, activation_byte, last, zero_point, row_sum,
             wgt_scale, act_scale,
      output ready
   );
endinterface

`default_nettype wire

### hdl/i8dd_rsp_if.sv
// Response channel: one dequantized 64-bit result per finished run.
// Depends on i8dd_pkg.
`default_nettype none

interface i8dd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [i8dd_pkg::OUT_W-1:0]   value;

   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

`default_nettype wire

### hdl/int8_dot_dequantize.sv
// Exact int8 dot product with per-channel fixed-point dequantization.
// Throughput: one request a cycle within a run; after the last request of a run the
// intake closes until the result loads; the shared 32x32 multiplier makes five passes.
// The response follows the finishing steps once the last request is accepted, later
// while an earlier response is still held. Reset (synchronous) clears the accumulator,
// the mode register and the response valid.
`default_nettype none
`include "int8_dot_dequantize_assert.svh"

module int8_dot_dequantize #(
   parameter int SCALE_FRAC = 24,
   parameter int OUT_FRAC   = 16
) (
   input  logic        clock,
   input  logic        reset,
   i8dd_req_if.sink    req_chan,
   i8dd_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import i8dd_pkg::*;

   cmd_type    cmd;
   status_type status;

   i8dd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   i8dd_datapath #(
      .SCALE_FRAC (SCALE_FRAC),
      .OUT_FRAC   (OUT_FRAC)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .weight_byte      (req_chan.weight_byte),
      .activation_byte  (req_chan.activation_byte),
      .last             (req_chan.last),
      .zero_point       (req_chan.zero_point),
      .row_sum          (req_chan.row_sum),
      .wgt_scale        (req_chan.wgt_scale),
      .act_scale        (req_chan.act_scale),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .value            (rsp_chan.value)
   );

   `I8DD_ASSERT_NXT(a_last_closes_intake, clock, reset, req_chan.valid && req_chan.ready && req_chan.last, !req_chan.ready, "intake open after last request")
   `I8DD_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, status.out_free, "response loaded over a pending one")
   `I8DD_ASSERT_NXT(a_load_gives_valid, clock, reset, cmd.out_load, rsp_chan.valid, "loaded response not presented")
   `I8DD_ASSERT_IMP(a_cmd_exclusive, clock, reset, 1'b1, $onehot0({cmd.accept, cmd.diff_en, cmd.mag_en, cmd.mul_en, cmd.round_en, cmd.out_load}), "overlapping datapath commands")

endmodule

`default_nettype wire

### hdl/i8dd_ctrl.sv
// Sequencer for the finishing steps after the last request of a run.
// Depends on i8dd_pkg.
`default_nettype none

module i8dd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   output i8dd_pkg::cmd_type      cmd,
   input  i8dd_pkg::status_type   status
);
   import i8dd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIFF  = 3'd1;
   localparam logic [2:0] ST_MAG   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.mul_step = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = ST_MAG;
         end
         ST_MAG: begin
            cmd.mag_en = 1'b1;
            step_in    = MUL_LL;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            step_in    = step_ff + 2'd1;
            if (step_ff == MUL_HH) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            // hold until the previous result has been taken
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= MUL_LL;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

### hdl/i8dd_datapath.sv
// Accumulator, zero-point correction, shared 32x32 multiplier, rounding,
// saturation and the result register. Depends on i8dd_pkg.
`default_nettype none

module i8dd_datapath #(
   parameter int SCALE_FRAC = 24,
   parameter int OUT_FRAC   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  i8dd_pkg::cmd_type                     cmd,
   output i8dd_pkg::status_type                  status,
   input  logic                                  csr_wr_en,
   input  logic                                  csr_wr_data,
   input  logic signed [i8dd_pkg::BYTE_W-1:0]    weight_byte,
   input  logic signed [i8dd_pkg::BYTE_W-1:0]    activation_byte,
   input  logic                                  last,
   input  logic signed [i8dd_pkg::BYTE_W-1:0]    zero_point,
   input  logic signed [i8dd_pkg::ROWSUM_W-1:0]  row_sum,
   input  logic        [i8dd_pkg::SCALE_W-1:0]   wgt_scale,
   input  logic        [i8dd_pkg::SCALE_W-1:0]   act_scale,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [i8dd_pkg::OUT_W-1:0]     value
);
   import i8dd_pkg::*;

   localparam int SHIFT = 2 * SCALE_FRAC - OUT_FRAC;
   localparam int RSH   = (SHIFT > 0) ? SHIFT : 0;
   localparam int LSH   = (SHIFT < 0) ? -SHIFT : 0;
   localparam int RND_W = PROD_W + 1 + LSH;

   logic                       asym_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in, acc_sum;
   logic signed [2*BYTE_W-1:0] pair_prod;

   logic signed [ACC_W-1:0]    fin_acc_ff;
   logic signed [BYTE_W-1:0]   zp_ff;
   logic signed [ROWSUM_W-1:0] rs_ff;
   logic [SCALE_W-1:0]         ws_ff, as_ff;

   logic signed [ZR_W-1:0]     zr;
   logic [DIFF_W-1:0]          zr_sel;
   logic [DIFF_W-1:0]          d_ff, d_in;
   logic [SPROD_W-1:0]         scale_ff;
   logic [DIFF_W-1:0]          mag_ff;
   logic                       neg_ff;

   logic [MUL_W-1:0]           mul_a, mul_b, mag_hi;
   logic [2*MUL_W-1:0]         mul_p;
   logic [PROD_W-1:0]          part, prod_ff, prod_in;

   logic [RND_W-1:0]           rnd_ext, rnd_bias, rnd_ff, rnd_in;
   logic                       over;
   logic [OUT_W-1:0]           mag64, sat_val;
   logic [OUT_W-1:0]           value_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   // accumulate
   assign pair_prod = weight_byte * activation_byte;
   assign acc_sum   = acc_ff + ACC_W'(pair_prod);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.accept) begin
         acc_in = last ? '0 : acc_sum;
      end
   end

   // zero-point correction
   assign zr     = zp_ff * rs_ff;
   assign zr_sel = asym_ff ? DIFF_W'(zr) : '0;
   assign d_in   = DIFF_W'(fin_acc_ff) - zr_sel;

   // shared multiplier: scale product first, then four partial products
   assign mag_hi = MUL_W'(mag_ff[DIFF_W-1:MUL_W]);

   always_comb begin
      mul_a = ws_ff;
      mul_b = as_ff;
      if (!cmd.diff_en) begin
         case (cmd.mul_step)
            MUL_LL: begin
               mul_a = mag_ff[MUL_W-1:0];
               mul_b = scale_ff[MUL_W-1:0];
            end
            MUL_LH: begin
               mul_a = mag_ff[MUL_W-1:0];
               mul_b = scale_ff[SPROD_W-1:MUL_W];
            end
            MUL_HL: begin
               mul_a = mag_hi;
               mul_b = scale_ff[MUL_W-1:0];
            end
            MUL_HH: begin
               mul_a = mag_hi;
               mul_b = scale_ff[SPROD_W-1:MUL_W];
            end
            default: begin
               mul_a = ws_ff;
               mul_b = as_ff;
            end
         endcase
      end
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      case (cmd.mul_step)
         MUL_LL:  part = PROD_W'(mul_p);
         MUL_LH:  part = PROD_W'(mul_p) << MUL_W;
         MUL_HL:  part = PROD_W'(mul_p) << MUL_W;
         MUL_HH:  part = PROD_W'(mul_p) << (2 * MUL_W);
         default: part = '0;
      endcase
   end

   assign prod_in = prod_ff + part;

   // round half away from zero on the magnitude, or exact left shift
   assign rnd_ext  = RND_W'(prod_ff);
   assign rnd_bias = (RND_W'(1) << RSH) >> 1;
   assign rnd_in   = ((rnd_ext + rnd_bias) >> RSH) << LSH;

   // saturate to the signed 64-bit range
   assign over  = |rnd_ff[RND_W-1:OUT_W];
   assign mag64 = rnd_ff[OUT_W-1:0];

   always_comb begin
      if (neg_ff) begin
         if (over || (mag64 > SAT_MIN)) begin
            sat_val = SAT_MIN;
         end else begin
            sat_val = -mag64;
         end
      end else begin
         if (over || mag64[OUT_W-1]) begin
            sat_val = SAT_MAX;
         end else begin
            sat_val = mag64;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asym_ff      <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            asym_ff <= csr_wr_data;
         end
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && last) begin
         fin_acc_ff <= acc_sum;
         zp_ff      <= zero_point;
         rs_ff      <= row_sum;
         ws_ff      <= wgt_scale;
         as_ff      <= act_scale;
      end
      if (cmd.diff_en) begin
         d_ff     <= d_in;
         scale_ff <= mul_p;
      end
      if (cmd.mag_en) begin
         neg_ff  <= d_ff[DIFF_W-1];
         mag_ff  <= d_ff[DIFF_W-1] ? -d_ff : d_ff;
         prod_ff <= '0;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.round_en) begin
         rnd_ff <= rnd_in;
      end
      if (cmd.out_load) begin
         value_ff <= sat_val;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign value     = value_ff;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for int8_dot_dequantize: directed table, then random runs.
// Depends on i8dd_pkg, i8dd_req_if, i8dd_rsp_if and the block itself.
module tb_top;
   import i8dd_pkg::*;

   localparam int SCALE_FRAC  = 24;
   localparam int OUT_FRAC    = 16;
   localparam int ROUND_SHIFT = 2 * SCALE_FRAC - OUT_FRAC;
   localparam logic [31:0] SCALE_ONE = 32'(1) << SCALE_FRAC;
   localparam logic [31:0] SCALE_MAX = 32'hFFFF_FFFF;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT   = 5000;
   localparam int DIR_N         = 20;
   localparam int RAND_PHASES   = 6;
   localparam int PHASE_ITEMS   = 232;

   typedef struct {
      logic signed [BYTE_W-1:0]   weight;
      logic signed [BYTE_W-1:0]   act;
      logic                       last;
      logic signed [BYTE_W-1:0]   zero_point;
      logic signed [ROWSUM_W-1:0] row_sum;
      logic [SCALE_W-1:0]         wscale;
      logic [SCALE_W-1:0]         ascale;
   } req_item_type;

   // count > 1 repeats the pair as non-last requests before the row itself
   typedef struct {
      bit                         mode;
      int unsigned                count;
      logic signed [BYTE_W-1:0]   weight;
      logic signed [BYTE_W-1:0]   act;
      logic                       last;
      logic signed [BYTE_W-1:0]   zero_point;
      logic signed [ROWSUM_W-1:0] row_sum;
      logic [SCALE_W-1:0]         wscale;
      logic [SCALE_W-1:0]         ascale;
      bit                         typed;
      logic [OUT_W-1:0]           value;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   i8dd_req_if req_bus ();
   i8dd_rsp_if rsp_bus ();

   int8_dot_dequantize #(
      .SCALE_FRAC(SCALE_FRAC),
      .OUT_FRAC  (OUT_FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // predictor state
   logic signed [ACC_W-1:0] dot_acc = '0;
   bit                      asym_mode_model = 1'b0;
   logic [OUT_W-1:0]        pending_values[$];
   int                      runs_sent = 0;
   int                      results_seen = 0;
   int                      errors = 0;
   bit                      idle_on = 1'b1;
   int                      quiet_cycles = 0;
   dir_row_type             dir_rows [DIR_N];

   function automatic logic [OUT_W-1:0] scale_round_sat(input longint diff,
                                                       input logic [31:0] ws,
                                                       input logic [31:0] as_);
      logic         neg;
      logic [63:0]  mag;
      logic [127:0] wide;
      neg  = diff < 0;
      mag  = neg ? 64'(-diff) : 64'(diff);
      wide = {64'd0, mag} * {96'd0, ws} * {96'd0, as_};
      // round to nearest, ties away from zero, on the magnitude
      if (ROUND_SHIFT > 0)
         wide = (wide + (128'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      else if (ROUND_SHIFT < 0)
         wide = wide << (-ROUND_SHIFT);
      if (neg)
         return (|wide[127:64] || wide[63:0] > SAT_MIN) ? SAT_MIN : -wide[63:0];
      return (|wide[127:64] || wide[63]) ? SAT_MAX : wide[63:0];
   endfunction

   function automatic bit dot_dequant_step(input req_item_type it,
                                           output logic [OUT_W-1:0] value);
      longint diff;
      value   = '0;
      dot_acc = dot_acc + it.weight * it.act;
      if (!it.last)
         return 1'b0;
      diff = dot_acc;
      if (asym_mode_model)
         diff = diff - longint'(it.zero_point) * longint'(it.row_sum);
      value   = scale_round_sat(diff, it.wscale, it.ascale);
      dot_acc = '0;
      return 1'b1;
   endfunction

   function automatic logic signed [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return -8'sd128;
         1: return 8'sd127;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return SCALE_MAX;
         2: return SCALE_ONE + $urandom_range(0, 65535) - 32768;
         3: return $urandom_range(0, 32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_item_type make_item(input bit last);
      req_item_type it;
      it.weight     = pick_byte();
      it.act        = pick_byte();
      it.last       = last;
      it.zero_point = pick_byte();
      it.row_sum    = ROWSUM_W'(int'($urandom_range(0, 1048576)) - 524288);
      it.wscale     = pick_scale();
      it.ascale     = pick_scale();
      return it;
   endfunction

   task automatic push_req(input req_item_type it, input bit typed,
                           input logic [OUT_W-1:0] typed_val);
      logic [OUT_W-1:0] v;
      req_bus.valid            <= 1'b1;
      req_bus.weight_byte      <= it.weight;
      req_bus.activation_byte  <= it.act;
      req_bus.last             <= it.last;
      req_bus.zero_point       <= it.zero_point;
      req_bus.row_sum          <= it.row_sum;
      req_bus.wgt_scale        <= it.wscale;
      req_bus.act_scale        <= it.ascale;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (dot_dequant_step(it, v)) begin
         pending_values.push_back(typed ? typed_val : v);
         runs_sent++;
      end
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // drain, then let the datapath settle before touching the mode bit
   task automatic wait_idle(input int tail);
      req_bus.valid <= 1'b0;
      while (results_seen < runs_sent)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_mode(input bit mode);
      wait_idle(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      asym_mode_model = mode;
   endtask

   // result receiver with random stalls
   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_values.size() == 0) begin
            $display("%0t: unexpected result %0d, nothing pending", $time, rsp_bus.value);
            errors++;
         end else if (rsp_bus.value !== pending_values[0]) begin
            $display("%0t: value mismatch, expected %0d, got %0d", $time,
                     $signed(pending_values[0]), rsp_bus.value);
            errors++;
            void'(pending_values.pop_front());
         end else begin
            void'(pending_values.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      int        i;
      int        k;
      int        ph;
      int        len;
      int        issued;
      bit        phase_mode [RAND_PHASES];

      dir_rows = '{
         // mode count  w     a    last zp    row_sum  wscale     ascale     typed value
         '{0, 1,    0,    0,   1, 0,    0,       SCALE_ONE, SCALE_ONE, 1, 64'd0},
         '{0, 1,    -128, -128, 1, 0,   0,       SCALE_ONE, SCALE_ONE, 1, 64'd1073741824},
         '{0, 1,    127,  -128, 1, 0,   0,       SCALE_ONE, SCALE_ONE, 1, -64'sd1065353216},
         '{0, 1,    127,  127, 0, 127,  524288,  SCALE_MAX, SCALE_MAX, 0, 64'd0},
         '{0, 1,    -1,   1,   1, -128, -524288, SCALE_ONE, SCALE_ONE, 0, 64'd0},
         '{0, 1,    1,    1,   1, 0,    0,       32'd1,     32'h8000_0000, 1, 64'd1},
         '{0, 1,    -1,   1,   1, 0,    0,       32'd1,     32'h8000_0000, 1, -64'sd1},
         '{0, 1,    1,    1,   1, 0,    0,       32'd1,     32'h7FFF_FFFF, 1, 64'd0},
         '{0, 1,    127,  127, 1, 0,    0,       32'd0,     SCALE_MAX, 1, 64'd0},
         '{0, 1,    127,  127, 1, 0,    0,       SCALE_MAX, SCALE_MAX, 0, 64'd0},
         '{0, 4,    -100, 77,  1, 0,    0,       32'h0123_4567, 32'h00AB_CDEF, 0, 64'd0},
         // runs of extreme pairs under the largest scales
         '{0, 16,   -128, -128, 1, 0,   0,       SCALE_MAX, SCALE_MAX, 0, 64'd0},
         '{0, 16,   127,  -128, 1, 0,   0,       SCALE_MAX, SCALE_MAX, 0, 64'd0},
         '{1, 1,    0,    0,   1, -128, 524288,  SCALE_ONE, SCALE_ONE, 1, 64'd4398046511104},
         '{1, 1,    0,    0,   1, 127,  -524288, SCALE_ONE, SCALE_ONE, 1, 64'd4363686772736},
         '{1, 1,    -128, -128, 1, -128, -524288, SCALE_ONE, SCALE_ONE, 1,
           -64'sd4396972769280},
         '{1, 2,    3,    4,   1, 10,   1000,    32'h0080_0000, 32'h0300_0000, 0, 64'd0},
         '{1, 1,    127,  127, 0, 5,    5,       SCALE_ONE, SCALE_ONE, 0, 64'd0},
         '{1, 1,    -128, 127, 1, -1,   1,       SCALE_MAX, 32'd1,     0, 64'd0},
         '{0, 1,    1,    1,   1, 127,  524288,  SCALE_ONE, SCALE_ONE, 1, 64'd65536}
      };
      phase_mode = '{1, 0, 1, 1, 0, 1};

      req_bus.valid            <= 1'b0;
      req_bus.weight_byte      <= '0;
      req_bus.activation_byte  <= '0;
      req_bus.last             <= 1'b0;
      req_bus.zero_point       <= '0;
      req_bus.row_sum          <= '0;
      req_bus.wgt_scale        <= '0;
      req_bus.act_scale        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_N; i++) begin
         if (dir_rows[i].mode != asym_mode_model)
            write_mode(dir_rows[i].mode);
         it.weight      = dir_rows[i].weight;
         it.act         = dir_rows[i].act;
         it.zero_point  = dir_rows[i].zero_point;
         it.row_sum     = dir_rows[i].row_sum;
         it.wscale      = dir_rows[i].wscale;
         it.ascale      = dir_rows[i].ascale;
         it.last        = 1'b0;
         for (k = 1; k < dir_rows[i].count; k++)
            push_req(it, 1'b0, '0);
         it.last = dir_rows[i].last;
         push_req(it, dir_rows[i].typed, dir_rows[i].value);
      end

      for (ph = 0; ph < RAND_PHASES; ph++) begin
         write_mode(phase_mode[ph]);
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            // quiet stretches now and then; none at all in the final phase
            idle_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (k = 0; k < len; k++) begin
               push_req(make_item(k == len - 1), 1'b0, '0);
               issued++;
            end
         end
      end

      wait_idle(20);
      if (pending_values.size() != 0)
         $display("%0t: %0d results never arrived", $time, pending_values.size());
      if (errors == 0 && pending_values.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/i8dd_pkg.sv
hdl/i8dd_req_if.sv
hdl/i8dd_rsp_if.sv
hdl/i8dd_ctrl.sv
hdl/i8dd_datapath.sv
hdl/int8_dot_dequantize.sv
tb/tb_top.sv
